// ===== rtl/rstb_pkg.sv =====
// ----------------------------------------------------------------------------
// Step tuner package
// Widths, constants, codes and the command and status words that pass
// between the tuner controller and its datapath.
// ----------------------------------------------------------------------------
package rstb_pkg;

   localparam int KHZ_W      = 16;
   localparam int FINE_W     = 16;
   localparam int NB_W       = 18;
   localparam int NF_W       = 18;
   localparam int POS_W      = 27;
   localparam int F_W        = 28;
   localparam int DVD_W      = 26;
   localparam int DVS_W      = 16;
   localparam int RADIX_W    = 2;
   localparam int Q_W        = 7;
   localparam int SQ_W       = 6;
   localparam int BFO_W      = 15;
   localparam int CAL_W      = 12;
   localparam int DIR_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int BFO_LIMIT   = 14000;
   localparam int HZ_PER_KHZ  = 1000;
   localparam int KHZ_MAX     = 65535;
   localparam int BFO_OUT_MAX = 16383;
   localparam int BFO_OUT_MIN = -16384;

   localparam logic [KHZ_W-1:0] BAND_LOW_RST  = 16'd520;
   localparam logic [KHZ_W-1:0] BAND_HIGH_RST = 16'd1710;
   localparam logic [DVS_W-1:0] STEP_RST      = 16'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIDEBAND_MODE = 3'd0,
      CSR_BAND_LOW      = 3'd1,
      CSR_BAND_HIGH     = 3'd2,
      CSR_STEP_SIZE     = 3'd3,
      CSR_BAND_CAL      = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_POS,
      DP_SNAP,
      DP_CORR,
      DP_FOLD,
      DP_FMUL,
      DP_CHECK
   } dp_op_type;

   typedef enum logic [1:0] {
      DIV_MOD,
      DIV_QUOT,
      DIV_CORR,
      DIV_SAVE
   } div_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POS,
      S_MOD,
      S_MOD_WAIT,
      S_SNAP,
      S_BRANCH,
      S_QUOT_WAIT,
      S_CORR,
      S_CORR_DIV,
      S_CORR_WAIT,
      S_FOLD,
      S_FMUL,
      S_CHECK,
      S_SAVE,
      S_SAVE_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      dp_op_type   op;
      logic        div_start;
      div_sel_type div_sel;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic sideband_path;
      logic set_item;
      logic need_fold;
      logic div_done;
   } dp_status_type;

endpackage

// ===== rtl/rstb_divider.sv =====
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division that retires RADIX_W quotient bits per cycle and holds
// the quotient and remainder after its done pulse until the next start.
// ----------------------------------------------------------------------------
module rstb_divider
   import rstb_pkg::*;
#(
   parameter int DVD_W   = 26,
   parameter int DVS_W   = 16,
   parameter int RADIX_W = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder,
   output logic             done
);

   localparam int ITER  = (DVD_W + RADIX_W - 1) / RADIX_W;
   localparam int PAD_W = ITER * RADIX_W;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [PAD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   step_rem;
   logic [PAD_W-1:0] step_quo;

   always_comb begin
      step_rem = {1'b0, rem_ff};
      step_quo = quo_ff;
      for (int i = 0; i < RADIX_W; i++) begin
         step_rem = {step_rem[DVS_W-1:0], step_quo[PAD_W-1]};
         step_quo = {step_quo[PAD_W-2:0], 1'b0};
         if (step_rem >= {1'b0, dvs_ff}) begin
            step_rem    = step_rem - {1'b0, dvs_ff};
            step_quo[0] = 1'b1;
         end
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = PAD_W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(ITER);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = step_quo;
         rem_in = step_rem[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff[DVD_W-1:0];
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== rtl/rstb_datapath.sv =====
// ----------------------------------------------------------------------------
// Step tuner datapath
// Configuration registers, tuned frequency and BFO state, the working
// registers of one item, the shared divider and the result word register.
// ----------------------------------------------------------------------------
module rstb_datapath
   import rstb_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic                         req_mode,
   input  logic signed [DIR_W-1:0]      req_direction,
   input  logic [KHZ_W-1:0]             req_target_freq_khz,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   output logic [KHZ_W-1:0]             rsp_frequency_khz,
   output logic signed [BFO_W-1:0]      rsp_bfo_hz,
   output logic signed [BFO_W-1:0]      rsp_bfo_drive_hz,
   output logic [KHZ_W-1:0]             rsp_saved_freq_khz,
   output logic                         rsp_freq_changed,
   output logic                         rsp_wrapped
);

   localparam int CORR_W = NB_W - 1;
   localparam int SUM_W  = FINE_W + 2;
   localparam int SAV_W  = KHZ_W + 2;

   localparam logic signed [NB_W-1:0]   LIMIT_NB    = NB_W'(BFO_LIMIT);
   localparam logic signed [NB_W-1:0]   LIMIT_NB_N  = NB_W'(-BFO_LIMIT);
   localparam logic signed [F_W-1:0]    HZ_F        = F_W'(HZ_PER_KHZ);
   localparam logic signed [NF_W-1:0]   NF_KHZ_MAX  = NF_W'(KHZ_MAX);
   localparam logic signed [SUM_W-1:0]  OUT_MAX     = SUM_W'(BFO_OUT_MAX);
   localparam logic signed [SUM_W-1:0]  OUT_MIN     = SUM_W'(BFO_OUT_MIN);
   localparam logic signed [SAV_W-1:0]  SAV_MAX     = SAV_W'(KHZ_MAX);

   // Configuration and tuner state.
   logic                      sideband_ff, sideband_in;
   logic [KHZ_W-1:0]          band_low_ff, band_low_in;
   logic [KHZ_W-1:0]          band_high_ff, band_high_in;
   logic [DVS_W-1:0]          step_ff, step_in;
   logic signed [CAL_W-1:0]   cal_ff, cal_in;
   logic [KHZ_W-1:0]          tuned_ff, tuned_in;
   logic signed [FINE_W-1:0]  fine_ff, fine_in;

   // Working registers of the current item.
   logic                      mode_ff, mode_in;
   logic                      up_ff, up_in;
   logic                      down_ff, down_in;
   logic                      path_ff, path_in;
   logic [KHZ_W-1:0]          target_ff, target_in;
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic signed [NF_W-1:0]    nf_ff, nf_in;
   logic signed [NB_W-1:0]    nb_ff, nb_in;
   logic [CORR_W-1:0]         corr_mag_ff, corr_mag_in;
   logic signed [F_W-1:0]     f_ff, f_in;
   logic signed [F_W-1:0]     lo_ref_ff, lo_ref_in;
   logic signed [F_W-1:0]     hi_ref_ff, hi_ref_in;
   logic                      wrap_ff, wrap_in;
   logic                      changed_ff, changed_in;

   // Result word.
   logic [KHZ_W-1:0]          out_freq_ff, out_freq_in;
   logic signed [BFO_W-1:0]   out_bfo_ff, out_bfo_in;
   logic signed [BFO_W-1:0]   out_drive_ff, out_drive_in;
   logic [KHZ_W-1:0]          out_saved_ff, out_saved_in;
   logic                      out_changed_ff, out_changed_in;
   logic                      out_wrap_ff, out_wrap_in;

   // Divider interface and combinational helpers.
   logic [DVD_W-1:0]          div_dividend;
   logic [DVS_W-1:0]          div_divisor;
   logic [DVD_W-1:0]          div_quo;
   logic [DVS_W-1:0]          div_rem;
   logic                      div_done;

   logic [DVS_W-1:0]          step_eff;
   logic signed [POS_W-1:0]   pos_khz;
   logic signed [POS_W-1:0]   pos_fine;
   logic signed [POS_W-1:0]   pos_neg;
   logic [DVD_W-1:0]          pos_mag;
   logic [DVS_W-1:0]          rem_nn;
   logic [DVS_W-1:0]          snapped;
   logic signed [NB_W-1:0]    delta;
   logic signed [NB_W-1:0]    fine_nb;
   logic signed [NF_W-1:0]    tuned_nf;
   logic signed [NF_W-1:0]    target_nf;
   logic signed [NF_W-1:0]    lo_nf;
   logic signed [NF_W-1:0]    hi_nf;
   logic signed [NB_W-1:0]    nb_neg;
   logic [CORR_W-1:0]         nb_mag;
   logic signed [NF_W-1:0]    k_nf;
   logic signed [NB_W-1:0]    corr_nb;
   logic signed [F_W-1:0]     nf_f;
   logic signed [F_W-1:0]     nb_f;
   logic                      low_pass;
   logic                      high_pass;
   logic [KHZ_W-1:0]          final_khz;
   logic signed [FINE_W-1:0]  fine_neg;
   logic [FINE_W-1:0]         fine_mag;
   logic signed [SUM_W-1:0]   fine_s;
   logic signed [SUM_W-1:0]   drive_s;
   logic signed [SAV_W-1:0]   saved_s;
   logic signed [SAV_W-1:0]   kq_s;
   logic                      need_fold;

   rstb_divider #(
      .DVD_W   (DVD_W),
      .DVS_W   (DVS_W),
      .RADIX_W (RADIX_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // Configuration writes.
   always_comb begin
      sideband_in  = sideband_ff;
      band_low_in  = band_low_ff;
      band_high_in = band_high_ff;
      step_in      = step_ff;
      cal_in       = cal_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SIDEBAND_MODE: sideband_in  = csr_wdata[0];
            CSR_BAND_LOW:      band_low_in  = csr_wdata[KHZ_W-1:0];
            CSR_BAND_HIGH:     band_high_in = csr_wdata[KHZ_W-1:0];
            CSR_STEP_SIZE:     step_in      = csr_wdata[DVS_W-1:0];
            CSR_BAND_CAL:      cal_in       = csr_wdata[CAL_W-1:0];
            default:           sideband_in  = sideband_ff;
         endcase
      end
   end

   // Arithmetic helpers.
   always_comb begin
      step_eff  = (step_ff == '0) ? DVS_W'(1) : step_ff;
      pos_khz   = $signed(POS_W'(tuned_ff) * POS_W'(HZ_PER_KHZ));
      pos_fine  = fine_ff;
      pos_neg   = -pos_ff;
      pos_mag   = pos_ff[POS_W-1] ? pos_neg[DVD_W-1:0] : pos_ff[DVD_W-1:0];

      rem_nn = div_rem;
      if (path_ff && pos_ff[POS_W-1] && (div_rem != '0)) begin
         rem_nn = step_eff - div_rem;
      end
      if (rem_nn == '0) begin
         snapped = step_eff;
      end else if (up_ff) begin
         snapped = step_eff - rem_nn;
      end else begin
         snapped = rem_nn;
      end
      if (up_ff) begin
         delta = $signed({2'b00, snapped});
      end else if (down_ff) begin
         delta = -$signed({2'b00, snapped});
      end else begin
         delta = '0;
      end

      fine_nb   = fine_ff;
      tuned_nf  = $signed({{(NF_W-KHZ_W){1'b0}}, tuned_ff});
      target_nf = $signed({{(NF_W-KHZ_W){1'b0}}, target_ff});
      lo_nf     = $signed({{(NF_W-KHZ_W){1'b0}}, band_low_ff});
      hi_nf     = $signed({{(NF_W-KHZ_W){1'b0}}, band_high_ff});

      nb_neg    = -nb_ff;
      nb_mag    = nb_ff[NB_W-1] ? nb_neg[CORR_W-1:0] : nb_ff[CORR_W-1:0];
      need_fold = path_ff && ((nb_ff > LIMIT_NB) || (nb_ff < LIMIT_NB_N));
      k_nf      = $signed({{(NF_W-Q_W){1'b0}}, div_quo[Q_W-1:0]});
      corr_nb   = $signed({1'b0, corr_mag_ff});

      nf_f = nf_ff;
      nb_f = nb_ff;

      if (path_ff) begin
         low_pass  = (f_ff < lo_ref_ff) || (nf_ff < 0);
         high_pass = (f_ff > hi_ref_ff) || (nf_ff > NF_KHZ_MAX);
      end else begin
         low_pass  = nf_ff < lo_nf;
         high_pass = nf_ff > hi_nf;
      end
      if (low_pass) begin
         final_khz = band_high_ff;
      end else if (high_pass) begin
         final_khz = band_low_ff;
      end else begin
         final_khz = nf_ff[KHZ_W-1:0];
      end

      fine_neg = -fine_ff;
      fine_mag = fine_ff[FINE_W-1] ? fine_neg : fine_ff;
      fine_s   = fine_ff;
      drive_s  = -(fine_s + SUM_W'(cal_ff));
      kq_s     = $signed({{(SAV_W-SQ_W){1'b0}}, div_quo[SQ_W-1:0]});
      if (fine_ff[FINE_W-1]) begin
         saved_s = $signed({2'b00, tuned_ff}) - kq_s;
      end else begin
         saved_s = $signed({2'b00, tuned_ff}) + kq_s;
      end
   end

   // Divider operand selection.
   always_comb begin
      case (cmd.div_sel)
         DIV_MOD: begin
            div_dividend = path_ff ? pos_mag : DVD_W'(tuned_ff);
            div_divisor  = step_eff;
         end
         DIV_QUOT: begin
            div_dividend = DVD_W'(nb_mag);
            div_divisor  = DVS_W'(BFO_LIMIT);
         end
         DIV_CORR: begin
            div_dividend = DVD_W'(corr_mag_ff);
            div_divisor  = DVS_W'(HZ_PER_KHZ);
         end
         DIV_SAVE: begin
            div_dividend = DVD_W'(fine_mag);
            div_divisor  = DVS_W'(HZ_PER_KHZ);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = step_eff;
         end
      endcase
   end

   // Item steps.
   always_comb begin
      mode_in     = mode_ff;
      up_in       = up_ff;
      down_in     = down_ff;
      path_in     = path_ff;
      target_in   = target_ff;
      pos_in      = pos_ff;
      nf_in       = nf_ff;
      nb_in       = nb_ff;
      corr_mag_in = corr_mag_ff;
      f_in        = f_ff;
      lo_ref_in   = lo_ref_ff;
      hi_ref_in   = hi_ref_ff;
      wrap_in     = wrap_ff;
      changed_in  = changed_ff;
      tuned_in    = tuned_ff;
      fine_in     = fine_ff;
      case (cmd.op)
         DP_CAPTURE: begin
            mode_in   = req_mode;
            up_in     = req_direction == DIR_W'(1);
            down_in   = req_direction[DIR_W-1];
            path_in   = !req_mode && sideband_ff;
            target_in = req_target_freq_khz;
         end
         DP_POS: begin
            pos_in = pos_khz + pos_fine;
         end
         DP_SNAP: begin
            if (path_ff) begin
               nf_in = tuned_nf;
               nb_in = fine_nb + delta;
            end else if (mode_ff) begin
               nf_in = target_nf;
               nb_in = '0;
            end else begin
               nf_in = tuned_nf + delta;
               nb_in = '0;
            end
         end
         DP_CORR: begin
            corr_mag_in = CORR_W'(CORR_W'(div_quo[Q_W-1:0]) * CORR_W'(BFO_LIMIT));
         end
         DP_FOLD: begin
            if (nb_ff[NB_W-1]) begin
               nf_in = nf_ff - k_nf;
               nb_in = nb_ff + corr_nb;
            end else begin
               nf_in = nf_ff + k_nf;
               nb_in = nb_ff - corr_nb;
            end
         end
         DP_FMUL: begin
            f_in      = nf_f * HZ_F + nb_f;
            lo_ref_in = $signed(F_W'(band_low_ff) * F_W'(HZ_PER_KHZ));
            hi_ref_in = $signed(F_W'(band_high_ff) * F_W'(HZ_PER_KHZ));
         end
         DP_CHECK: begin
            wrap_in    = low_pass || high_pass;
            changed_in = final_khz != tuned_ff;
            tuned_in   = final_khz;
            fine_in    = (low_pass || high_pass) ? '0 : nb_ff[FINE_W-1:0];
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // Result word.
   always_comb begin
      out_freq_in    = out_freq_ff;
      out_bfo_in     = out_bfo_ff;
      out_drive_in   = out_drive_ff;
      out_saved_in   = out_saved_ff;
      out_changed_in = out_changed_ff;
      out_wrap_in    = out_wrap_ff;
      if (cmd.out_load) begin
         out_freq_in    = tuned_ff;
         out_changed_in = changed_ff;
         out_wrap_in    = wrap_ff;
         if (fine_s > OUT_MAX) begin
            out_bfo_in = OUT_MAX[BFO_W-1:0];
         end else if (fine_s < OUT_MIN) begin
            out_bfo_in = OUT_MIN[BFO_W-1:0];
         end else begin
            out_bfo_in = fine_s[BFO_W-1:0];
         end
         if (drive_s > OUT_MAX) begin
            out_drive_in = OUT_MAX[BFO_W-1:0];
         end else if (drive_s < OUT_MIN) begin
            out_drive_in = OUT_MIN[BFO_W-1:0];
         end else begin
            out_drive_in = drive_s[BFO_W-1:0];
         end
         if (saved_s < 0) begin
            out_saved_in = '0;
         end else if (saved_s > SAV_MAX) begin
            out_saved_in = SAV_MAX[KHZ_W-1:0];
         end else begin
            out_saved_in = saved_s[KHZ_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sideband_ff  <= 1'b0;
         band_low_ff  <= BAND_LOW_RST;
         band_high_ff <= BAND_HIGH_RST;
         step_ff      <= STEP_RST;
         cal_ff       <= '0;
         tuned_ff     <= BAND_LOW_RST;
         fine_ff      <= '0;
      end else begin
         sideband_ff  <= sideband_in;
         band_low_ff  <= band_low_in;
         band_high_ff <= band_high_in;
         step_ff      <= step_in;
         cal_ff       <= cal_in;
         tuned_ff     <= tuned_in;
         fine_ff      <= fine_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      up_ff          <= up_in;
      down_ff        <= down_in;
      path_ff        <= path_in;
      target_ff      <= target_in;
      pos_ff         <= pos_in;
      nf_ff          <= nf_in;
      nb_ff          <= nb_in;
      corr_mag_ff    <= corr_mag_in;
      f_ff           <= f_in;
      lo_ref_ff      <= lo_ref_in;
      hi_ref_ff      <= hi_ref_in;
      wrap_ff        <= wrap_in;
      changed_ff     <= changed_in;
      out_freq_ff    <= out_freq_in;
      out_bfo_ff     <= out_bfo_in;
      out_drive_ff   <= out_drive_in;
      out_saved_ff   <= out_saved_in;
      out_changed_ff <= out_changed_in;
      out_wrap_ff    <= out_wrap_in;
   end

   assign status.sideband_path = path_ff;
   assign status.set_item      = mode_ff;
   assign status.need_fold     = need_fold;
   assign status.div_done      = div_done;

   assign rsp_frequency_khz  = out_freq_ff;
   assign rsp_bfo_hz         = out_bfo_ff;
   assign rsp_bfo_drive_hz   = out_drive_ff;
   assign rsp_saved_freq_khz = out_saved_ff;
   assign rsp_freq_changed   = out_changed_ff;
   assign rsp_wrapped        = out_wrap_ff;

endmodule

// ===== rtl/rstb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Step tuner controller
// Sequences the datapath through grid snapping, BFO folding, the band check
// and the saved frequency, and drives the handshakes of both channels.
// ----------------------------------------------------------------------------
module rstb_ctrl
   import rstb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free      = !rsp_valid_ff || !rsp_stall;
      state_in      = state_ff;
      cmd.op        = DP_NOP;
      cmd.div_start = 1'b0;
      cmd.div_sel   = DIV_MOD;
      cmd.out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_CAPTURE;
               state_in = S_POS;
            end
         end
         S_POS: begin
            cmd.op   = DP_POS;
            state_in = status.set_item ? S_SNAP : S_MOD;
         end
         S_MOD: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MOD;
            state_in      = S_MOD_WAIT;
         end
         S_MOD_WAIT: begin
            cmd.div_sel = DIV_MOD;
            if (status.div_done) begin
               state_in = S_SNAP;
            end
         end
         S_SNAP: begin
            cmd.op   = DP_SNAP;
            state_in = S_BRANCH;
         end
         S_BRANCH: begin
            if (status.need_fold) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_QUOT;
               state_in      = S_QUOT_WAIT;
            end else begin
               state_in = S_FMUL;
            end
         end
         S_QUOT_WAIT: begin
            cmd.div_sel = DIV_QUOT;
            if (status.div_done) begin
               state_in = S_CORR;
            end
         end
         S_CORR: begin
            cmd.op   = DP_CORR;
            state_in = S_CORR_DIV;
         end
         S_CORR_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_CORR;
            state_in      = S_CORR_WAIT;
         end
         S_CORR_WAIT: begin
            cmd.div_sel = DIV_CORR;
            if (status.div_done) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.op   = DP_FOLD;
            state_in = S_FMUL;
         end
         S_FMUL: begin
            cmd.op   = DP_FMUL;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op   = DP_CHECK;
            state_in = S_SAVE;
         end
         S_SAVE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SAVE;
            state_in      = S_SAVE_WAIT;
         end
         S_SAVE_WAIT: begin
            cmd.div_sel = DIV_SAVE;
            if (status.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.div_sel = DIV_SAVE;
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/radio_step_tuner_with_bfo_top.sv =====
// ----------------------------------------------------------------------------
// Step tuner with BFO offset
// Keeps the tuned frequency in kHz and, in sideband mode, a fine BFO offset
// in Hz; one result word for every tune or set word.
// ----------------------------------------------------------------------------
// Usage: a word enters on the req_ channel when req_valid is high and
// req_stall is low; its single result word leaves on the rsp_ channel when
// rsp_valid is high and rsp_stall is low. Registers are written through the
// csr_ port, one register per cycle; the user must write them only while no
// word is in flight, which the block does not enforce. One word is worked at
// a time. A shared divider that retires two quotient bits per cycle does all
// divisions: a set word skips the grid division, and a sideband tune word that
// moves BFO whole multiples into kHz runs two more divisions than one that does not.
// The next word is accepted as soon as a result word sits in the output
// register, so a stalled receiver holds that word while the next one is
// worked; the block waits only when a second result is ready before the
// first was taken. Reset is synchronous: it loads the register reset values,
// sets the frequency to 520 kHz with no BFO offset and empties the output.
// ----------------------------------------------------------------------------
module radio_step_tuner_with_bfo_top
   import rstb_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic signed [DIR_W-1:0]     req_direction,
   input  logic [KHZ_W-1:0]            req_target_freq_khz,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [KHZ_W-1:0]            rsp_frequency_khz,
   output logic signed [BFO_W-1:0]     rsp_bfo_hz,
   output logic signed [BFO_W-1:0]     rsp_bfo_drive_hz,
   output logic [KHZ_W-1:0]            rsp_saved_freq_khz,
   output logic                        rsp_freq_changed,
   output logic                        rsp_wrapped
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rstb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rstb_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_mode            (req_mode),
      .req_direction       (req_direction),
      .req_target_freq_khz (req_target_freq_khz),
      .cmd                 (cmd),
      .status              (status),
      .rsp_frequency_khz   (rsp_frequency_khz),
      .rsp_bfo_hz          (rsp_bfo_hz),
      .rsp_bfo_drive_hz    (rsp_bfo_drive_hz),
      .rsp_saved_freq_khz  (rsp_saved_freq_khz),
      .rsp_freq_changed    (rsp_freq_changed),
      .rsp_wrapped         (rsp_wrapped)
   );

endmodule

// ===== verif/radio_step_tuner_with_bfo_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step tuner with BFO offset: testbench
// Drives tune and set words through the request channel under several
// register settings and idle patterns, predicts each result word from a
// behavioral copy of the tuner or takes it from a fixed script row, and compares it field by field.
// ----------------------------------------------------------------------------
module radio_step_tuner_with_bfo_top_tb;
   import rstb_pkg::*;

   localparam int CYCLE_LIMIT     = 1500000;
   localparam int SETTLE_CYCLES   = 100;
   localparam int RANDOM_PHASES   = 12;
   localparam int WORDS_PER_PHASE = 117;
   localparam int SCRIPT_LEN      = 27;

   localparam logic       MODE_TUNE     = 1'b0;
   localparam logic       MODE_SET      = 1'b1;
   localparam logic [1:0] DIR_NONE      = 2'b00;
   localparam logic [1:0] DIR_UP        = 2'b01;
   localparam logic [1:0] DIR_DOWN_WIDE = 2'b10;
   localparam logic [1:0] DIR_DOWN      = 2'b11;

   typedef struct {
      int sideband;
      int low_khz;
      int high_khz;
      int step;
      int cal_hz;
   } band_setup_t;

   typedef struct packed {
      logic [KHZ_W-1:0]        khz;
      logic signed [BFO_W-1:0] bfo;
      logic signed [BFO_W-1:0] drive;
      logic [KHZ_W-1:0]        saved;
      logic                    changed;
      logic                    wrapped;
   } tuner_word_t;

   typedef struct {
      int               setup_id;
      logic             mode;
      logic [1:0]       dir;
      logic [KHZ_W-1:0] target;
      bit               pinned;
      tuner_word_t      pinned_word;
   } script_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_mode = MODE_TUNE;
   logic signed [DIR_W-1:0] req_direction = '0;
   logic [KHZ_W-1:0]        req_target_freq_khz = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [KHZ_W-1:0]        rsp_frequency_khz;
   logic signed [BFO_W-1:0] rsp_bfo_hz;
   logic signed [BFO_W-1:0] rsp_bfo_drive_hz;
   logic [KHZ_W-1:0]        rsp_saved_freq_khz;
   logic                    rsp_freq_changed;
   logic                    rsp_wrapped;

   band_setup_t setups [5] = '{
      '{0, 520, 1710, 1, 0},
      '{1, 7000, 7300, 5000, -2048},
      '{1, 0, 65535, 65535, 2047},
      '{0, 2000, 1000, 0, 0},
      '{0, 0, 65535, 65535, 0}
   };

   script_row_t script [SCRIPT_LEN] = '{
      '{0, MODE_TUNE, DIR_UP,        16'd0,     1'b1,
        '{16'd521, 15'sd0, 15'sd0, 16'd521, 1'b1, 1'b0}},
      '{0, MODE_TUNE, DIR_DOWN,      16'd0,     1'b1,
        '{16'd520, 15'sd0, 15'sd0, 16'd520, 1'b1, 1'b0}},
      '{0, MODE_TUNE, DIR_DOWN,      16'd0,     1'b1,
        '{16'd1710, 15'sd0, 15'sd0, 16'd1710, 1'b1, 1'b1}},
      '{0, MODE_TUNE, DIR_UP,        16'd0,     1'b1,
        '{16'd520, 15'sd0, 15'sd0, 16'd520, 1'b1, 1'b1}},
      '{0, MODE_TUNE, DIR_NONE,      16'd0,     1'b1,
        '{16'd520, 15'sd0, 15'sd0, 16'd520, 1'b0, 1'b0}},
      '{0, MODE_TUNE, DIR_DOWN_WIDE, 16'd0,     1'b1,
        '{16'd1710, 15'sd0, 15'sd0, 16'd1710, 1'b1, 1'b1}},
      '{0, MODE_SET,  DIR_UP,        16'd0,     1'b1,
        '{16'd1710, 15'sd0, 15'sd0, 16'd1710, 1'b0, 1'b1}},
      '{0, MODE_SET,  DIR_DOWN_WIDE, 16'd65535, 1'b1,
        '{16'd520, 15'sd0, 15'sd0, 16'd520, 1'b1, 1'b1}},
      '{0, MODE_SET,  DIR_NONE,      16'd1000,  1'b1,
        '{16'd1000, 15'sd0, 15'sd0, 16'd1000, 1'b1, 1'b0}},
      '{1, MODE_TUNE, DIR_UP,        16'd0,     1'b1,
        '{16'd7300, 15'sd0, 15'sd2048, 16'd7300, 1'b1, 1'b1}},
      '{1, MODE_SET,  DIR_UP,        16'd7000,  1'b0, '0},
      '{1, MODE_TUNE, DIR_UP,        16'd0,     1'b0, '0},
      '{1, MODE_TUNE, DIR_UP,        16'd0,     1'b0, '0},
      '{1, MODE_TUNE, DIR_UP,        16'd0,     1'b0, '0},
      '{1, MODE_SET,  DIR_DOWN,      16'd7000,  1'b0, '0},
      '{1, MODE_TUNE, DIR_DOWN,      16'd0,     1'b0, '0},
      '{1, MODE_TUNE, DIR_DOWN,      16'd0,     1'b0, '0},
      '{1, MODE_TUNE, DIR_DOWN_WIDE, 16'd0,     1'b0, '0},
      '{2, MODE_SET,  DIR_NONE,      16'd0,     1'b0, '0},
      '{2, MODE_TUNE, DIR_DOWN,      16'd0,     1'b0, '0},
      '{2, MODE_TUNE, DIR_UP,        16'd0,     1'b0, '0},
      '{2, MODE_TUNE, DIR_NONE,      16'd0,     1'b0, '0},
      '{3, MODE_SET,  DIR_UP,        16'd1500,  1'b0, '0},
      '{3, MODE_TUNE, DIR_UP,        16'd0,     1'b0, '0},
      '{4, MODE_SET,  DIR_DOWN_WIDE, 16'd65535, 1'b0, '0},
      '{4, MODE_TUNE, DIR_UP,        16'd0,     1'b0, '0},
      '{4, MODE_TUNE, DIR_DOWN,      16'd0,     1'b0, '0}
   };

   band_setup_t active_setup = '{0, 520, 1710, 1, 0};
   int          track_khz = 520;
   int          track_bfo_hz = 0;
   tuner_word_t predicted_words [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   radio_step_tuner_with_bfo_top uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Distance of one step after snapping the position onto the step grid.
   function automatic longint grid_move(input longint pos, input longint step, input int dir);
      longint r;
      r = pos % step;
      if (r < 0) r += step;
      if (r == 0) return step;
      return (dir > 0) ? step - r : r;
   endfunction

   function automatic tuner_word_t predict_tuning(input logic m, input logic [1:0] d,
                                                  input logic [KHZ_W-1:0] target);
      tuner_word_t w;
      longint step, lo, hi, pos, nf, nb, corr, f;
      int dir, old_khz;
      logic wrap;
      dir = (d == DIR_UP) ? 1 : (d == DIR_NONE) ? 0 : -1;
      step = (active_setup.step == 0) ? 1 : active_setup.step;
      lo = active_setup.low_khz;
      hi = active_setup.high_khz;
      old_khz = track_khz;
      wrap = 1'b0;
      nb = 0;
      if (m == MODE_TUNE && active_setup.sideband != 0) begin
         pos = longint'(track_khz) * HZ_PER_KHZ + track_bfo_hz;
         nb = track_bfo_hz + dir * grid_move(pos, step, dir);
         nf = track_khz;
         if (nb > BFO_LIMIT || nb < -BFO_LIMIT) begin
            corr = (nb / BFO_LIMIT) * BFO_LIMIT;
            nf += corr / HZ_PER_KHZ;
            nb -= corr;
         end
         f = nf * HZ_PER_KHZ + nb;
         if (f < lo * HZ_PER_KHZ || nf < 0) begin
            nf = hi;
            nb = 0;
            wrap = 1'b1;
         end else if (f > hi * HZ_PER_KHZ || nf > KHZ_MAX) begin
            nf = lo;
            nb = 0;
            wrap = 1'b1;
         end
      end else begin
         if (m == MODE_TUNE)
            nf = track_khz + dir * grid_move(track_khz, step, dir);
         else
            nf = target;
         if (nf < lo) begin
            nf = hi;
            wrap = 1'b1;
         end else if (nf > hi) begin
            nf = lo;
            wrap = 1'b1;
         end
         nb = 0;
      end
      track_khz = int'(nf & 64'hFFFF);
      track_bfo_hz = int'(nb);
      w.khz = KHZ_W'(track_khz);
      w.bfo = BFO_W'(clamp_to(nb, BFO_OUT_MIN, BFO_OUT_MAX));
      w.drive = BFO_W'(clamp_to(-(nb + active_setup.cal_hz), BFO_OUT_MIN, BFO_OUT_MAX));
      w.saved = KHZ_W'(clamp_to(track_khz + nb / HZ_PER_KHZ, 0, KHZ_MAX));
      w.changed = (track_khz != old_khz);
      w.wrapped = wrap;
      return w;
   endfunction

   function automatic band_setup_t random_setup();
      band_setup_t s;
      int span;
      s.sideband = ($urandom_range(9) < 6) ? 1 : 0;
      span = $urandom_range(2000);
      s.low_khz = $urandom_range(KHZ_MAX - span);
      s.high_khz = s.low_khz + span;
      case ($urandom_range(9))
         0: begin
            s.low_khz = 0;
            s.high_khz = KHZ_MAX;
         end
         1: begin
            s.low_khz = s.high_khz;
            s.high_khz = s.high_khz - span;
         end
         default: ;
      endcase
      case ($urandom_range(9))
         0: s.step = 0;
         1: s.step = KHZ_MAX;
         2: s.step = $urandom_range(KHZ_MAX);
         default: s.step = s.sideband ? $urandom_range(3000, 1) : $urandom_range(span / 16 + 1, 1);
      endcase
      s.cal_hz = int'($urandom_range(4095)) - 2048;
      return s;
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want_v,
                              input logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s expected %0d got %0d", name, want_v, got_v);
         mismatches++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_setup(input band_setup_t s);
      wait_drained();
      write_reg(CSR_SIDEBAND_MODE, CSR_DATA_W'(s.sideband));
      write_reg(CSR_BAND_LOW, CSR_DATA_W'(s.low_khz));
      write_reg(CSR_BAND_HIGH, CSR_DATA_W'(s.high_khz));
      write_reg(CSR_STEP_SIZE, CSR_DATA_W'(s.step));
      write_reg(CSR_BAND_CAL, CSR_DATA_W'(s.cal_hz));
      csr_we <= 1'b0;
      active_setup = s;
   endtask

   task automatic send_word(input logic m, input logic [1:0] d, input logic [KHZ_W-1:0] tgt,
                            input bit pinned, input tuner_word_t pinned_word);
      tuner_word_t w;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_direction <= d;
      req_target_freq_khz <= tgt;
      do @(posedge clock); while (req_stall);
      w = predict_tuning(m, d, tgt);
      predicted_words.push_back(pinned ? pinned_word : w);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      tuner_word_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_words.size() == 0) begin
            $error("result word with no prediction waiting");
            mismatches++;
         end else begin
            want = predicted_words.pop_front();
            check_field("frequency_khz", want.khz, rsp_frequency_khz);
            check_field("bfo_hz", want.bfo, rsp_bfo_hz);
            check_field("bfo_drive_hz", want.drive, rsp_bfo_drive_hz);
            check_field("saved_freq_khz", want.saved, rsp_saved_freq_khz);
            check_field("freq_changed", want.changed, rsp_freq_changed);
            check_field("wrapped", want.wrapped, rsp_wrapped);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int active_id;
      int heading;
      int pick;
      int target;
      logic [1:0] d;
      active_id = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].setup_id != active_id) begin
            program_setup(setups[script[i].setup_id]);
            active_id = script[i].setup_id;
         end
         send_word(script[i].mode, script[i].dir, script[i].target,
                   script[i].pinned, script[i].pinned_word);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_setup(random_setup());
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 80;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 80;
            end
            default: begin
               send_idle_pct = 17;
               stall_pct = 17;
            end
         endcase
         heading = 1;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n == WORDS_PER_PHASE / 2)
               wait_drained();
            if ($urandom_range(9) == 0)
               heading = -heading;
            pick = $urandom_range(99);
            if (pick < 8) begin
               target = $urandom_range(active_setup.low_khz, active_setup.high_khz);
               target = int'(clamp_to(target + int'($urandom_range(6)) - 3, 0, KHZ_MAX));
               send_word(MODE_SET, 2'($urandom_range(3)), KHZ_W'(target), 1'b0, '0);
            end else if (pick < 12) begin
               send_word(MODE_SET, 2'($urandom_range(3)), KHZ_W'($urandom_range(KHZ_MAX)),
                         1'b0, '0);
            end else if (pick < 16) begin
               send_word(MODE_TUNE, DIR_NONE, KHZ_W'($urandom_range(KHZ_MAX)), 1'b0, '0);
            end else begin
               if (heading > 0)
                  d = DIR_UP;
               else
                  d = $urandom_range(1) ? DIR_DOWN : DIR_DOWN_WIDE;
               send_word(MODE_TUNE, d, KHZ_W'($urandom_range(KHZ_MAX)), 1'b0, '0);
            end
         end
      end

      wait_drained();
      if (mismatches == 0 && predicted_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
